// ===== rtl/rrts_pkg.sv =====
package rrts_pkg;

    localparam int TASK_COUNT = 8;
    localparam int IDX_W      = $clog2(TASK_COUNT);
    localparam int TICK_W     = 32;
    localparam int RUN_W      = 3;
    localparam int MASK_W     = 8;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 48;

    typedef logic [IDX_W-1:0]      task_idx_t;
    typedef logic [TASK_COUNT-1:0] task_vec_t;
    typedef logic [TICK_W-1:0]     tick_t;

    typedef enum logic [IN_USER_W-1:0] {
        OP_TICK  = 1'b0,
        OP_DELAY = 1'b1
    } op_t;

endpackage

// ===== rtl/round_robin_task_scheduler.sv =====
// Channel   Dir  Fields (tdata / tuser, lowest bit first)
// s_axis    in   tuser: operation (0 tick, 1 delay); tdata: delay_ticks[31:0]
// m_axis    out  tdata: running_task[2:0], ready_mask[7:0], tick_now[31:0], 5 zero bits
//
// One event per cycle sustained while m_axis is not stalled. An event is held in an
// input register, then settled in one pass (parallel wake compares, one wrap-around
// add, rotating priority pick) into the scheduler state, which offers the result word.
// The scheduler state itself serves as the result register: it only moves when
// the result slot is empty or being taken, so a stalled m_axis holds everything.
// Reset: all tasks ready, tick count zero, task 1 current, no word pending.
module round_robin_task_scheduler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rrts_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // delay_ticks[31:0]
    input  logic [rrts_pkg::IN_USER_W-1:0]  s_axis_tuser,   // operation
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rrts_pkg::OUT_DATA_W-1:0] m_axis_tdata    // running_task, ready_mask,
                                                            // tick_now, zero fill
);

    localparam int WIDE_W = (rrts_pkg::IDX_W > rrts_pkg::RUN_W) ?
                            rrts_pkg::IDX_W : rrts_pkg::RUN_W;

    // Input register
    logic                  in_valid_reg;
    rrts_pkg::op_t         in_op_reg;
    rrts_pkg::tick_t       in_delay_reg;

    // Scheduler state, doubling as the result register
    logic                  out_valid_reg;
    rrts_pkg::task_vec_t   blocked_reg;
    rrts_pkg::task_vec_t   blocked_next;
    rrts_pkg::tick_t       tick_reg;
    rrts_pkg::tick_t       tick_next;
    rrts_pkg::task_idx_t   current_reg;
    rrts_pkg::task_idx_t   current_next;
    rrts_pkg::tick_t       wake_reg [rrts_pkg::TASK_COUNT];
    rrts_pkg::tick_t       wake_value;
    logic                  wake_write;

    logic                  advance;
    rrts_pkg::tick_t       tick_inc;
    rrts_pkg::task_vec_t   ready_vec;
    rrts_pkg::task_idx_t   chosen;
    logic                  do_choose;

    logic [WIDE_W-1:0]             run_wide;
    logic [rrts_pkg::RUN_W-1:0]    run_out;
    logic [rrts_pkg::MASK_W-1:0]   mask_out;

    // Settle the held event when the result slot is free or being drained.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg    <= rrts_pkg::op_t'(s_axis_tuser);
            in_delay_reg <= s_axis_tdata;
        end
    end

    // Event evaluation
    assign tick_inc = tick_reg + rrts_pkg::TICK_W'(1);

    always_comb
    begin
        blocked_next = blocked_reg;
        tick_next    = tick_reg;
        wake_write   = 1'b0;
        wake_value   = tick_reg + in_delay_reg;
        do_choose    = 1'b0;
        case (in_op_reg)
            rrts_pkg::OP_TICK:
            begin
                tick_next = tick_inc;
                for (int i = 1; i < rrts_pkg::TASK_COUNT; i++)
                begin
                    if (blocked_reg[i] && wake_reg[i] == tick_inc)
                    begin
                        blocked_next[i] = 1'b0;
                    end
                end
                do_choose = 1'b1;
            end
            default:
            begin
                // Delay from idle leaves everything as it is.
                if (current_reg != '0)
                begin
                    wake_write                = 1'b1;
                    blocked_next[current_reg] = 1'b1;
                    do_choose                 = 1'b1;
                end
            end
        endcase
        blocked_next[0] = 1'b0;
        ready_vec       = ~blocked_next;
    end

    rrts_pick u_pick (
        .current (current_reg),
        .ready   (ready_vec),
        .chosen  (chosen)
    );

    assign current_next = do_choose ? chosen : current_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            blocked_reg   <= '0;
            tick_reg      <= '0;
            current_reg   <= rrts_pkg::IDX_W'(1);
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                blocked_reg   <= blocked_next;
                tick_reg      <= tick_next;
                current_reg   <= current_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Wake ticks are only compared while the task is blocked, which needs a write first.
    always_ff @(posedge clk)
    begin
        if (advance && wake_write)
        begin
            wake_reg[current_reg] <= wake_value;
        end
    end

    // Result word
    assign run_wide = WIDE_W'(current_reg);
    assign run_out  = run_wide[rrts_pkg::RUN_W-1:0];

    always_comb
    begin
        mask_out = '0;
        for (int i = 0; i < rrts_pkg::MASK_W; i++)
        begin
            if (i < rrts_pkg::TASK_COUNT)
            begin
                mask_out[i] = (i == 0) || !blocked_reg[i % rrts_pkg::TASK_COUNT];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = rrts_pkg::OUT_DATA_W'({tick_reg, mask_out, run_out});

endmodule

// ===== rtl/rrts_pick.sv =====
// Round-robin: first ready user task after current (itself last), else idle.
module rrts_pick (
    input  rrts_pkg::task_idx_t current,
    input  rrts_pkg::task_vec_t ready,
    output rrts_pkg::task_idx_t chosen
);

    localparam int SUM_W = rrts_pkg::IDX_W + 1;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] cand;

    // Walk from farthest to nearest so the nearest ready task wins.
    always_comb
    begin
        chosen = '0;
        sum    = '0;
        cand   = '0;
        for (int k = rrts_pkg::TASK_COUNT; k >= 1; k--)
        begin
            sum = SUM_W'(current) + SUM_W'(k);
            if (sum >= SUM_W'(rrts_pkg::TASK_COUNT))
            begin
                cand = sum - SUM_W'(rrts_pkg::TASK_COUNT);
            end
            else
            begin
                cand = sum;
            end
            if (cand != '0 && ready[cand[rrts_pkg::IDX_W-1:0]])
            begin
                chosen = cand[rrts_pkg::IDX_W-1:0];
            end
        end
    end

endmodule
